// ===== sv/cobs_dec_pkg.sv =====
package cobs_dec_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned STATUS_W = 3;
    localparam logic [BYTE_W-1:0] MAX_CODE = 8'hFF;

    // output queue depth, one input transaction pushes at most two entries
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned MAX_PUSH = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 3'd0,
        STATUS_ZERO_CODE  = 3'd1,
        STATUS_TRUNCATED  = 3'd2,
        STATUS_EXTRA_DELIM = 3'd3,
        STATUS_COUNT_MISS = 3'd4
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              byte_valid;
        logic              frame_end;
        status_t           status;
    } cobs_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] bytes_left;
        logic              block_full;
        logic [BYTE_W-1:0] delims_left;
        logic              frame_start;
        logic              discarding;
    } cobs_state_t;

    localparam cobs_state_t STATE_RESET = '{
        bytes_left:  '0,
        block_full:  1'b0,
        delims_left: '0,
        frame_start: 1'b1,
        discarding:  1'b0
    };

endpackage

// ===== sv/cobs_frame_decoder_core.sv =====
// COBS frame decoder core: takes one encoded byte per transaction and gives
// decoded bytes, re-inserted delimiters and one end-of-frame status item per
// frame. The delimiter value comes from cfg_wdata; the user must write it only
// while the block is idle; the block itself does not enforce this. An input
// transaction can be taken every cycle while the output queue has room: the
// byte is registered, decoded in a single pass of logic and its zero, one or
// two results are pushed into a four-entry output queue, from whose registers
// they reach the m_ side. s_ready drops only while the input register holds a
// byte and the queue has fewer than two free entries, so a stalled m_ side
// backs up into s_ after a few transactions. After an error the end item comes
// out at once and the rest of the frame is swallowed up to and including the
// byte marked frame_last.
module cobs_frame_decoder_core
    import cobs_dec_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    // delimiter register write
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_wdata,

    // encoded byte channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_in,
    input  logic              s_frame_last,
    input  logic [BYTE_W-1:0] s_expected_count,

    // decoded result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_data_out,
    output logic              m_byte_valid,
    output logic              m_frame_end,
    output logic [STATUS_W-1:0] m_status
);

    // configuration
    logic [BYTE_W-1:0] delimiter_reg;

    // input register stage
    logic              stage_valid_reg;
    logic              stage_valid_next;
    logic [BYTE_W-1:0] stage_data_reg;
    logic              stage_last_reg;
    logic [BYTE_W-1:0] stage_count_reg;

    // decoder state
    cobs_state_t       state_reg;
    cobs_state_t       state_next;

    // decode results
    logic [1:0]        step_push;
    logic [1:0]        push_cnt;
    cobs_item_t        item0;
    cobs_item_t        item1;
    cobs_item_t        out_item;

    // queue status
    logic              room_for_two;
    logic [FIFO_CW-1:0] fill;
    logic              advance;
    logic              s_take;

    // the staged byte is decoded and leaves once the queue can hold its results
    assign advance = stage_valid_reg && room_for_two;
    assign s_ready = !stage_valid_reg || advance;
    assign s_take  = s_valid && s_ready;
    assign push_cnt = advance ? step_push : 2'd0;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (s_take) begin
            stage_valid_next = 1'b1;
        end else if (advance) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg   <= '0;
            stage_valid_reg <= 1'b0;
            state_reg       <= STATE_RESET;
        end else begin
            if (cfg_we) begin
                delimiter_reg <= cfg_wdata;
            end
            stage_valid_reg <= stage_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            stage_data_reg  <= s_data_in;
            stage_last_reg  <= s_frame_last;
            stage_count_reg <= s_expected_count;
        end
    end

    cobs_dec_step u_step (
        .state_cur      (state_reg),
        .delimiter      (delimiter_reg),
        .data_in        (stage_data_reg),
        .frame_last     (stage_last_reg),
        .expected_count (stage_count_reg),
        .state_nxt      (state_next),
        .push_cnt       (step_push),
        .item0          (item0),
        .item1          (item1)
    );

    cobs_dec_fifo u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_cnt     (push_cnt),
        .push_item0   (item0),
        .push_item1   (item1),
        .room_for_two (room_for_two),
        .fill         (fill),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_item     (out_item)
    );

    assign m_data_out   = out_item.data_out;
    assign m_byte_valid = out_item.byte_valid;
    assign m_frame_end  = out_item.frame_end;
    assign m_status     = out_item.status;

`ifndef SYNTHESIS
    // queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill <= FIFO_CW'(FIFO_DEPTH))
        else $error("output queue overflow");

    // results only go in while the queue has room for two
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt != 2'd0) |-> room_for_two)
        else $error("push without queue room");

    // a stalled input register keeps its byte for the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && !advance) |=> stage_valid_reg)
        else $error("staged byte lost");

    // a queued item is either a data byte or an end item, never both
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_byte_valid != m_frame_end))
        else $error("malformed result item");
`endif

endmodule

// ===== sv/cobs_dec_step.sv =====
module cobs_dec_step
    import cobs_dec_pkg::*;
(
    input  cobs_state_t       state_cur,
    input  logic [BYTE_W-1:0] delimiter,
    input  logic [BYTE_W-1:0] data_in,
    input  logic              frame_last,
    input  logic [BYTE_W-1:0] expected_count,
    output cobs_state_t       state_nxt,
    output logic [1:0]        push_cnt,
    output cobs_item_t        item0,
    output cobs_item_t        item1
);

    cobs_item_t        items [MAX_PUSH];
    logic [1:0]        n;
    logic [BYTE_W-1:0] bl;
    logic              bf;
    logic [BYTE_W-1:0] dl;
    logic [BYTE_W-1:0] bl_new;
    logic              bf_new;
    logic              done;
    logic              error_stop;

    function automatic cobs_item_t data_item(input logic [BYTE_W-1:0] b);
        cobs_item_t it;
        it.data_out   = b;
        it.byte_valid = 1'b1;
        it.frame_end  = 1'b0;
        it.status     = STATUS_OK;
        return it;
    endfunction

    function automatic cobs_item_t end_item(input status_t st);
        cobs_item_t it;
        it.data_out   = '0;
        it.byte_valid = 1'b0;
        it.frame_end  = 1'b1;
        it.status     = st;
        return it;
    endfunction

    always_comb begin
        state_nxt  = state_cur;
        n          = 2'd0;
        items[0]   = '0;
        items[1]   = '0;
        bl         = state_cur.frame_start ? '0 : state_cur.bytes_left;
        bf         = state_cur.frame_start ? 1'b0 : state_cur.block_full;
        dl         = state_cur.frame_start ? expected_count : state_cur.delims_left;
        bl_new     = '0;
        bf_new     = 1'b0;
        done       = 1'b0;
        error_stop = 1'b0;

        if (state_cur.discarding) begin
            if (frame_last) begin
                state_nxt.bytes_left  = '0;
                state_nxt.block_full  = 1'b0;
                state_nxt.frame_start = 1'b1;
                state_nxt.discarding  = 1'b0;
            end
        end else begin
            state_nxt.frame_start = 1'b0;
            state_nxt.delims_left = dl;
            state_nxt.block_full  = bf;
            if (bl == '0) begin
                // code byte
                if (data_in == '0) begin
                    error_stop = 1'b1;
                    items[0]   = end_item(STATUS_ZERO_CODE);
                    n          = 2'd1;
                    state_nxt.bytes_left = '0;
                    if (frame_last) begin
                        state_nxt.block_full  = 1'b0;
                        state_nxt.frame_start = 1'b1;
                    end else begin
                        state_nxt.discarding = 1'b1;
                    end
                end else begin
                    bl_new = data_in - 8'd1;
                    bf_new = (data_in == MAX_CODE);
                end
            end else begin
                items[0] = data_item(data_in);
                n        = 2'd1;
                bl_new   = bl - 8'd1;
                bf_new   = bf;
            end

            if (!error_stop) begin
                done = (bl_new == '0);
                state_nxt.bytes_left = bl_new;
                state_nxt.block_full = bf_new;
                if (done && frame_last) begin
                    items[n[0]] = end_item((dl != '0) ? STATUS_COUNT_MISS : STATUS_OK);
                    n = n + 2'd1;
                    state_nxt.block_full  = 1'b0;
                    state_nxt.frame_start = 1'b1;
                end else if (done && !bf_new) begin
                    if (dl == '0) begin
                        items[n[0]] = end_item(STATUS_EXTRA_DELIM);
                        state_nxt.discarding = 1'b1;
                    end else begin
                        items[n[0]] = data_item(delimiter);
                        state_nxt.delims_left = dl - 8'd1;
                    end
                    n = n + 2'd1;
                end else if (!done && frame_last) begin
                    items[n[0]] = end_item(STATUS_TRUNCATED);
                    n = n + 2'd1;
                    state_nxt.bytes_left  = '0;
                    state_nxt.block_full  = 1'b0;
                    state_nxt.frame_start = 1'b1;
                end
            end
        end
    end

    assign push_cnt = n;
    assign item0    = items[0];
    assign item1    = items[1];

endmodule

// ===== sv/cobs_dec_fifo.sv =====
module cobs_dec_fifo
    import cobs_dec_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         push_cnt,
    input  cobs_item_t         push_item0,
    input  cobs_item_t         push_item1,
    output logic               room_for_two,
    output logic [FIFO_CW-1:0] fill,
    output logic               out_valid,
    input  logic               out_ready,
    output cobs_item_t         out_item
);

    cobs_item_t         entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;
    logic               pop;

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_item     = entry_reg[rd_ptr_reg];
    assign fill         = count_reg;
    assign room_for_two = (count_reg <= FIFO_CW'(FIFO_DEPTH - MAX_PUSH));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push_item0;
        end
        if (push_cnt == 2'd2) begin
            entry_reg[wr_ptr_reg + FIFO_AW'(1)] <= push_item1;
        end
    end

endmodule

// ===== tb/cobs_frame_decoder_core_tb.sv =====
import cobs_dec_pkg::*;

class cobs_frame_scoreboard;
    logic [BYTE_W-1:0] delim_value;
    logic [BYTE_W-1:0] bytes_left;
    logic [BYTE_W-1:0] delims_left;
    bit                block_full;
    bit                frame_start;
    bit                discarding;
    cobs_item_t        decoded_q[$];
    int                n_errors;

    function new();
        delim_value = '0;
        delims_left = '0;
        n_errors    = 0;
        restart();
    endfunction

    function void restart();
        bytes_left  = '0;
        block_full  = 1'b0;
        frame_start = 1'b1;
        discarding  = 1'b0;
    endfunction

    function void expect_data(logic [BYTE_W-1:0] d);
        cobs_item_t it;
        it = '{data_out: d, byte_valid: 1'b1, frame_end: 1'b0, status: STATUS_OK};
        decoded_q = {decoded_q, it};
    endfunction

    function void expect_end(status_t st);
        cobs_item_t it;
        it = '{data_out: '0, byte_valid: 1'b0, frame_end: 1'b1, status: st};
        decoded_q = {decoded_q, it};
    endfunction

    // block done: delimiter or extra-delimiter end, frame end, or nothing after a full block
    function void close_block(bit last);
        if (last) begin
            expect_end(delims_left != 0 ? STATUS_COUNT_MISS : STATUS_OK);
            restart();
        end else if (!block_full) begin
            if (delims_left == 0) begin
                expect_end(STATUS_EXTRA_DELIM);
                discarding = 1'b1;
            end else begin
                delims_left = delims_left - 1'b1;
                expect_data(delim_value);
            end
        end
    endfunction

    function void decode_byte(logic [BYTE_W-1:0] d, bit last, logic [BYTE_W-1:0] cnt);
        if (discarding) begin
            if (last)
                restart();
            return;
        end
        if (frame_start) begin
            delims_left = cnt;
            frame_start = 1'b0;
            bytes_left  = '0;
            block_full  = 1'b0;
        end
        if (bytes_left == 0) begin
            if (d == 0) begin
                expect_end(STATUS_ZERO_CODE);
                if (last)
                    restart();
                else
                    discarding = 1'b1;
                return;
            end
            bytes_left = d - 1'b1;
            block_full = (d == MAX_CODE);
            if (bytes_left == 0)
                close_block(last);
            else if (last) begin
                expect_end(STATUS_TRUNCATED);
                restart();
            end
            return;
        end
        expect_data(d);
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0)
            close_block(last);
        else if (last) begin
            expect_end(STATUS_TRUNCATED);
            restart();
        end
    endfunction

    task report(string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task check_item(logic [BYTE_W-1:0] d, logic bv, logic fe, logic [STATUS_W-1:0] st);
        cobs_item_t want;
        if (decoded_q.size() == 0) begin
            report($sformatf("unexpected result data %02h valid %b end %b status %0d",
                             d, bv, fe, st));
            return;
        end
        want = decoded_q.pop_front();
        if (d !== want.data_out || bv !== want.byte_valid || fe !== want.frame_end ||
            st !== want.status)
            report($sformatf("got data %02h valid %b end %b status %0d, want %02h %b %b %0d",
                             d, bv, fe, st, want.data_out, want.byte_valid,
                             want.frame_end, want.status));
    endtask
endclass

module cobs_frame_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                aclk;
    logic                aresetn          = 1'b0;
    logic                cfg_we           = 1'b0;
    logic [BYTE_W-1:0]   cfg_wdata        = '0;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_data_in        = '0;
    logic                s_frame_last     = 1'b0;
    logic [BYTE_W-1:0]   s_expected_count = '0;
    logic                m_valid;
    logic                m_ready          = 1'b0;
    logic [BYTE_W-1:0]   m_data_out;
    logic                m_byte_valid;
    logic                m_frame_end;
    logic [STATUS_W-1:0] m_status;

    cobs_frame_scoreboard sb = new();
    int items_sent = 0;
    // when set, neither side idles
    bit calm = 1'b0;

    cobs_frame_decoder_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_in       (s_data_in),
        .s_frame_last    (s_frame_last),
        .s_expected_count(s_expected_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_out      (m_data_out),
        .m_byte_valid    (m_byte_valid),
        .m_frame_end     (m_frame_end),
        .m_status        (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side: random back-pressure, changed on the falling edge
    always @(negedge aclk) begin
        m_ready = calm ? 1'b1 : ($urandom_range(99) >= 34);
    end

    // every accepted result transaction is checked against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_item(m_data_out, m_byte_valid, m_frame_end, m_status);
    end

    // one input transaction; valid is left high after acceptance so the next
    // call can present its byte without a drop in between
    task automatic send_byte(logic [BYTE_W-1:0] d, bit last, logic [BYTE_W-1:0] cnt);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 34) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_data_in        = d;
        s_frame_last     = last;
        s_expected_count = cnt;
        do @(posedge aclk); while (!s_ready);
        sb.decode_byte(d, last, cnt);
        items_sent++;
    endtask

    // stop sending, let every expected result out, then give the block time
    // to finish transactions that produce nothing
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.decoded_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_delim(logic [BYTE_W-1:0] v);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we    = 1'b0;
        sb.delim_value = v;
    endtask

    // well-formed frame with random content, sometimes broken on purpose
    task automatic send_frame(bit want_full);
        logic [BYTE_W-1:0] enc[$];
        int                code_at[$];
        int                nblk, ndelim, code, len, fault, b, j;
        logic [BYTE_W-1:0] cnt;
        nblk   = $urandom_range(1, 5);
        ndelim = 0;
        for (b = 0; b < nblk; b++) begin
            // mostly short blocks, a few longer, a full block on request
            if (want_full && b == 0)
                code = MAX_CODE;
            else if ($urandom_range(15) == 0)
                code = $urandom_range(9, 40);
            else
                code = $urandom_range(1, 8);
            code_at = {code_at, enc.size()};
            enc     = {enc, code[7:0]};
            for (j = 1; j < code; j++)
                enc = {enc, 8'($urandom_range(0, 255))};
            if (b != nblk - 1 && code != MAX_CODE)
                ndelim++;
        end
        cnt   = 8'(ndelim);
        len   = enc.size();
        fault = $urandom_range(9);
        case (fault)
            0: cnt = 8'($urandom_range(0, 255));          // arbitrary count
            1: cnt = 8'(ndelim + 1);                      // count left over at the end
            2: if (ndelim > 0) cnt = 8'(ndelim - 1);      // one delimiter too many
            3: len = $urandom_range(1, enc.size());       // cut short
            4: enc[code_at[$urandom_range(0, code_at.size() - 1)]] = '0; // zero code
            default: ;
        endcase
        for (j = 0; j < len; j++)
            send_byte(enc[j], j == len - 1, j == 0 ? cnt : 8'($urandom_range(0, 255)));
    endtask

    // garbage bytes, always closed by a last byte so the next frame is clean
    task automatic send_noise();
        int n, j;
        n = $urandom_range(1, 6);
        for (j = 0; j < n; j++)
            send_byte(8'($urandom_range(0, 255)), j == n - 1 || $urandom_range(3) == 0,
                      8'($urandom_range(0, 255)));
    endtask

    task automatic run_random(int n_items, bit want_full);
        int target;
        bit first;
        target = items_sent + n_items;
        first  = 1'b1;
        while (items_sent < target) begin
            if ($urandom_range(9) == 0)
                send_noise();
            else begin
                send_frame(first && want_full);
                first = 1'b0;
            end
        end
    endtask

    initial begin
        // synchronous reset held, then released on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // phase 0: delimiter at its top value, directed cases first
        write_delim(8'hFF);
        send_byte(8'h01, 1'b1, 8'h00);          // single empty block, clean end
        send_byte(8'h00, 1'b1, 8'h00);          // zero code on the last byte
        send_byte(8'h03, 1'b0, 8'h01);          // two blocks, data equal to the delimiter
        send_byte(8'hFF, 1'b0, 8'h00);
        send_byte(8'h00, 1'b0, 8'h00);
        send_byte(8'h02, 1'b0, 8'h00);
        send_byte(8'h80, 1'b1, 8'h00);
        send_byte(8'h02, 1'b0, 8'h00);          // delimiter due with count at zero
        send_byte(8'h01, 1'b0, 8'h00);
        send_byte(8'h01, 1'b1, 8'h00);          // dropped, closes the frame
        send_byte(8'h01, 1'b0, 8'hFF);          // count left over at the end
        send_byte(8'h01, 1'b1, 8'h00);
        send_byte(8'h04, 1'b0, 8'h00);          // frame ends inside a block
        send_byte(8'h7F, 1'b1, 8'h00);
        send_byte(8'h05, 1'b1, 8'h00);          // long code on the last byte
        send_byte(8'h00, 1'b0, 8'h03);          // zero code mid-frame, rest dropped
        send_byte(8'h55, 1'b0, 8'hAA);
        send_byte(8'hAA, 1'b1, 8'h55);
        run_random(170, 1'b1);
        drain();

        // phase 1: delimiter at zero
        write_delim(8'h00);
        run_random(140, 1'b0);
        drain();

        // phase 2: random delimiter, no idling on either side
        write_delim(8'($urandom_range(1, 254)));
        calm = 1'b1;
        run_random(140, 1'b0);
        drain();
        calm = 1'b0;

        // phase 3: another random delimiter, idling back on
        write_delim(8'($urandom_range(0, 255)));
        run_random(140, 1'b0);
        drain();
        repeat (20) @(posedge aclk);

        if (sb.n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
